/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/drt_pkg.sv */
package drt_pkg;

  // table geometry
  localparam int DEFAULT_DEPTH = 32;
  localparam int RESULT_CAP    = 32;

  // field widths
  localparam int KEY_W   = 32;
  localparam int ADDR_W  = 64;
  localparam int COUNT_W = 21;
  localparam int INC_W   = 9;
  localparam int SIZE_W  = 29;

  localparam logic [SIZE_W-1:0] SIZE_MAX_BYTES = 29'h1000_0000;
  localparam logic [INC_W-1:0]  INC_RESET      = 9'd32;

  // configuration register indexes
  localparam logic [1:0] REG_VIEW_INC    = 2'd0;
  localparam logic [1:0] REG_SAMPLER_INC = 2'd1;
  localparam logic [1:0] REG_PLAYER_EN   = 2'd2;

  // range kinds
  localparam logic [1:0] KIND_VIEW    = 2'd0;
  localparam logic [1:0] KIND_SAMPLER = 2'd1;

  typedef enum logic [2:0] {
    CMD_ADD        = 3'd0,
    CMD_SET_PLAYER = 3'd1,
    CMD_REMOVE     = 3'd2,
    CMD_LOOKUP     = 3'd3,
    CMD_READOUT    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_KEY_PRESENT = 3'd1,
    STAT_NOT_FOUND   = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_IGNORED     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN2,
    S_DONE,
    S_RDONE
  } state_e;

endpackage

/* rtl/descriptor_range_table.sv */
// Table of up to TABLE_DEPTH descriptor ranges with add, set-player, remove, lookup and
// ordered readout. Add, set-player, remove and the lookup and readout of a view or sampler
// kind walk the table one entry per cycle through the single read port of the entry memory,
// which is the one shared compare path. Add, set-player and lookup make one pass, remove of
// a present key two, and a readout of n ranges n+1 passes (n passes once 32 are listed).
// Kind-ignored lookup and readout go straight to the result without a scan; commands 5 to 7
// are dropped on accept. The input is not ready while a command runs; a finished result
// waits in the output register without holding off the next item.
`include "assert_macros.svh"

module descriptor_range_table
  import drt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // heap_key[31:0], descriptor_count[52:32], address[116:53], zero fill
  input  logic [119:0] s_axis_tdata,
  // cmd[2:0], heap_kind[4:3], lookup_side[5]
  input  logic [5:0]   s_axis_tuser,
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found_key[31:0], capture_base[95:32], player_base[159:96], range_bytes[188:160], zero fill
  output logic [191:0] m_axis_tdata,
  // hit[0], changed[1], status[4:2]
  output logic [4:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam int NW = $clog2(RESULT_CAP + 1);

  // input unpacking
  logic [2:0]         in_cmd;
  logic [1:0]         in_kind;
  logic               in_side;
  logic [KEY_W-1:0]   in_key;
  logic [COUNT_W-1:0] in_count;
  logic [ADDR_W-1:0]  in_addr;
  logic               in_take;

  assign in_cmd   = s_axis_tuser[2:0];
  assign in_kind  = s_axis_tuser[4:3];
  assign in_side  = s_axis_tuser[5];
  assign in_key   = s_axis_tdata[31:0];
  assign in_count = s_axis_tdata[52:32];
  assign in_addr  = s_axis_tdata[116:53];
  assign in_take  = s_axis_tvalid && s_axis_tready && (in_cmd <= CMD_READOUT);

  // entry memory
  logic [KEY_W-1:0]  mem_key  [TABLE_DEPTH];
  logic              mem_kind [TABLE_DEPTH];
  logic [ADDR_W-1:0] mem_cap  [TABLE_DEPTH];
  logic [ADDR_W-1:0] mem_play [TABLE_DEPTH];
  logic [SIZE_W-1:0] mem_size [TABLE_DEPTH];

  logic              we_all, we_play;
  logic [IW-1:0]     wa;
  logic [ADDR_W-1:0] wd_play;
  logic [SIZE_W-1:0] wd_size;
  logic [IW-1:0]     ra;

  logic [KEY_W-1:0]  rd_key_q;
  logic              rd_kind_q;
  logic [ADDR_W-1:0] rd_cap_q, rd_play_q;
  logic [SIZE_W-1:0] rd_size_q;

  // control state
  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d, cidx_q, cidx_d, pidx_q, pidx_d;
  logic             vflag_q, vflag_d, sflag_q, sflag_d;
  logic [INC_W-1:0] view_inc_q, view_inc_d, samp_inc_q, samp_inc_d;
  logic             pen_q, pen_d;
  logic             m_valid_q, m_valid_d;
  logic             found_q, found_d, kfound_q, kfound_d, free_found_q, free_found_d;
  logic             pend_q, pend_d, have_prev_q, have_prev_d;
  logic [NW-1:0]    n_q, n_d;

  // command payload and scan results
  cmd_e               cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [1:0]         kind_q, kind_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic               side_q, side_d;
  logic [IW-1:0]      e_idx_q, e_idx_d, free_idx_q, free_idx_d;
  logic               e_kind_q, e_kind_d;
  logic [ADDR_W-1:0]  e_cap_q, e_cap_d, e_play_q, e_play_d;
  logic [TABLE_DEPTH-1:0] mc_q, mc_d, mp0_q, mp0_d, mp1_q, mp1_d;
  logic [KEY_W-1:0]   best_key_q, best_key_d, pend_key_q, pend_key_d;
  logic [ADDR_W-1:0]  best_cap_q, best_cap_d, best_play_q, best_play_d;
  logic [ADDR_W-1:0]  best_start_q, best_start_d, prev_q, prev_d;
  logic [ADDR_W-1:0]  pend_cap_q, pend_cap_d, pend_play_q, pend_play_d;
  logic [SIZE_W-1:0]  best_size_q, best_size_d, pend_size_q, pend_size_d;
  logic               chg_q, chg_d;

  // output register
  logic               o_hit_q, o_hit_d, o_chg_q, o_chg_d, o_last_q, o_last_d;
  logic [KEY_W-1:0]   o_key_q, o_key_d;
  logic [ADDR_W-1:0]  o_cap_q, o_cap_d, o_play_q, o_play_d;
  logic [SIZE_W-1:0]  o_bytes_q, o_bytes_d;
  status_e            o_stat_q, o_stat_d;

  // scan helpers
  logic [CW-1:0]      cm1;
  logic [IW-1:0]      pi;
  logic               ent_v, kind_hit, idx_sel;
  logic [ADDR_W-1:0]  s_sel;
  logic               out_free, found_eff;
  logic [29:0]        prod;
  logic [INC_W-1:0]   inc_sel;
  logic [TABLE_DEPTH-1:0] ptmp;

  assign cm1      = cnt_q - 1'b1;
  assign pi       = cm1[IW-1:0];
  assign ra       = (cnt_q < CW'(TABLE_DEPTH)) ? cnt_q[IW-1:0] : '0;
  assign ent_v    = valid_q[pi];
  assign kind_hit = ({1'b0, rd_kind_q} == kind_q);
  assign idx_sel  = side_q ? pidx_q[pi] : cidx_q[pi];
  assign s_sel    = side_q ? rd_play_q : rd_cap_q;
  assign out_free = !m_valid_q || m_axis_tready;
  assign found_eff = found_q && (n_q < NW'(RESULT_CAP));

  // range size of an add, saturated
  assign inc_sel = kind_q[0] ? samp_inc_q : view_inc_q;
  assign prod    = {9'b0, count_q} * {21'b0, inc_sel};
  assign wd_size = (prod > {1'b0, SIZE_MAX_BYTES}) ? SIZE_MAX_BYTES : prod[SIZE_W-1:0];

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we_all) begin
      mem_key[wa]  <= key_q;
      mem_kind[wa] <= kind_q[0];
      mem_cap[wa]  <= addr_q;
      mem_size[wa] <= wd_size;
    end
    if (we_all || we_play) begin
      mem_play[wa] <= wd_play;
    end
    rd_key_q  <= mem_key[ra];
    rd_kind_q <= mem_kind[ra];
    rd_cap_q  <= mem_cap[ra];
    rd_play_q <= mem_play[ra];
    rd_size_q <= mem_size[ra];
  end

  // sequencer
  always_comb begin
    state_d = state_q;       cnt_d = cnt_q;
    valid_d = valid_q;       cidx_d = cidx_q;       pidx_d = pidx_q;
    vflag_d = vflag_q;       sflag_d = sflag_q;
    view_inc_d = view_inc_q; samp_inc_d = samp_inc_q; pen_d = pen_q;
    found_d = found_q;       kfound_d = kfound_q;   free_found_d = free_found_q;
    pend_d = pend_q;         have_prev_d = have_prev_q; n_d = n_q;
    cmd_d = cmd_q;   key_d = key_q;   kind_d = kind_q;   count_d = count_q;
    addr_d = addr_q; side_d = side_q;
    e_idx_d = e_idx_q; e_kind_d = e_kind_q; e_cap_d = e_cap_q; e_play_d = e_play_q;
    free_idx_d = free_idx_q;
    mc_d = mc_q; mp0_d = mp0_q; mp1_d = mp1_q;
    best_key_d = best_key_q; best_cap_d = best_cap_q; best_play_d = best_play_q;
    best_size_d = best_size_q; best_start_d = best_start_q; prev_d = prev_q;
    pend_key_d = pend_key_q; pend_cap_d = pend_cap_q; pend_play_d = pend_play_q;
    pend_size_d = pend_size_q; chg_d = chg_q;
    o_hit_d = o_hit_q; o_chg_d = o_chg_q; o_last_d = o_last_q; o_key_d = o_key_q;
    o_cap_d = o_cap_q; o_play_d = o_play_q; o_bytes_d = o_bytes_q; o_stat_d = o_stat_q;
    m_valid_d = m_axis_tready ? 1'b0 : m_valid_q;
    we_all = 1'b0; we_play = 1'b0; wa = '0; wd_play = '0;
    ptmp = pidx_q;

    // configuration writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VIEW_INC:    view_inc_d = cfg_data_i;
        REG_SAMPLER_INC: samp_inc_d = cfg_data_i;
        REG_PLAYER_EN:   pen_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = cmd_e'(in_cmd); key_d = in_key; kind_d = in_kind;
          count_d = in_count; addr_d = in_addr; side_d = in_side;
          cnt_d = '0; found_d = 1'b0; kfound_d = 1'b0; free_found_d = 1'b0;
          mc_d = '0; mp0_d = '0; mp1_d = '0;
          case (cmd_e'(in_cmd))
            CMD_ADD, CMD_SET_PLAYER, CMD_REMOVE: state_d = S_SCAN;
            CMD_LOOKUP: state_d = in_kind[1] ? S_DONE : S_SCAN;
            CMD_READOUT: begin
              if (in_kind[1]) begin
                state_d = S_DONE;
              end else begin
                chg_d = in_kind[0] ? sflag_q : vflag_q;
                if (in_kind[0]) sflag_d = 1'b0;
                else vflag_d = 1'b0;
                pend_d = 1'b0; have_prev_d = 1'b0; n_d = '0;
                state_d = S_SCAN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN, S_SCAN2: begin
        cnt_d = cnt_q + 1'b1;
        // one entry per cycle on the registered read data
        if (cnt_q != '0) begin
          if (state_q == S_SCAN2) begin
            if (ent_v && rd_kind_q == e_kind_q) begin
              if (rd_cap_q == e_cap_q) mc_d[pi] = 1'b1;
              if (rd_play_q == e_play_q) mp0_d[pi] = 1'b1;
            end
          end else begin
            case (cmd_q)
              CMD_ADD, CMD_SET_PLAYER, CMD_REMOVE: begin
                if (ent_v && rd_key_q == key_q && !kfound_q) begin
                  kfound_d = 1'b1; e_idx_d = pi; e_kind_d = rd_kind_q;
                  e_cap_d = rd_cap_q; e_play_d = rd_play_q;
                end
                if (!ent_v && !free_found_q) begin
                  free_found_d = 1'b1; free_idx_d = pi;
                end
                if (ent_v && kind_hit && rd_cap_q == addr_q) mc_d[pi] = 1'b1;
                if (ent_v && rd_play_q == addr_q) begin
                  if (rd_kind_q) mp1_d[pi] = 1'b1;
                  else mp0_d[pi] = 1'b1;
                end
              end
              CMD_LOOKUP: begin
                if (ent_v && kind_hit && idx_sel && addr_q != '0 && s_sel <= addr_q &&
                    (!found_q || s_sel > best_start_q)) begin
                  found_d = 1'b1; best_start_d = s_sel; best_key_d = rd_key_q;
                  best_cap_d = rd_cap_q; best_play_d = rd_play_q; best_size_d = rd_size_q;
                end
              end
              CMD_READOUT: begin
                if (ent_v && kind_hit && cidx_q[pi] && (!have_prev_q || rd_cap_q > prev_q) &&
                    (!found_q || rd_cap_q < best_start_q)) begin
                  found_d = 1'b1; best_start_d = rd_cap_q; best_key_d = rd_key_q;
                  best_cap_d = rd_cap_q; best_play_d = rd_play_q; best_size_d = rd_size_q;
                end
              end
              default: ;
            endcase
          end
        end
        // end of a pass
        if (cnt_q == CW'(TABLE_DEPTH)) begin
          if (cmd_q == CMD_READOUT) begin
            state_d = S_RDONE;
          end else if (cmd_q == CMD_REMOVE && state_q == S_SCAN && kfound_d) begin
            state_d = S_SCAN2; cnt_d = '0; mc_d = '0; mp0_d = '0;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1; state_d = S_IDLE;
          o_hit_d = 1'b0; o_key_d = key_q; o_cap_d = '0; o_play_d = '0; o_bytes_d = '0;
          o_chg_d = 1'b0; o_last_d = 1'b1; o_stat_d = STAT_OK;
          case (cmd_q)
            CMD_ADD: begin
              if (kfound_q) begin
                o_stat_d = STAT_KEY_PRESENT;
              end else if (kind_q[1]) begin
                o_stat_d = STAT_IGNORED;
              end else if (!free_found_q) begin
                o_stat_d = STAT_FULL;
              end else begin
                we_all = 1'b1; wa = free_idx_q; wd_play = '0;
                valid_d[free_idx_q] = 1'b1;
                cidx_d = cidx_q & ~mc_q;
                cidx_d[free_idx_q] = 1'b1;
                pidx_d[free_idx_q] = 1'b0;
                if (kind_q[0]) sflag_d = 1'b1;
                else vflag_d = 1'b1;
              end
            end
            CMD_SET_PLAYER: begin
              if (!kfound_q) begin
                o_stat_d = STAT_NOT_FOUND;
              end else begin
                we_play = 1'b1; wa = e_idx_q; wd_play = addr_q;
                ptmp[e_idx_q] = 1'b0;
                if (pen_q) begin
                  ptmp = ptmp & ~(e_kind_q ? mp1_q : mp0_q);
                  ptmp[e_idx_q] = 1'b1;
                end
                pidx_d = ptmp;
              end
            end
            CMD_REMOVE: begin
              if (!kfound_q) begin
                o_stat_d = STAT_NOT_FOUND;
              end else begin
                cidx_d = cidx_q & ~mc_q;
                if (pen_q) ptmp = pidx_q & ~mp0_q;
                ptmp[e_idx_q] = 1'b0;
                pidx_d = ptmp;
                valid_d[e_idx_q] = 1'b0;
                cidx_d[e_idx_q] = 1'b0;
              end
            end
            CMD_LOOKUP: begin
              o_key_d = '0;
              if (kind_q[1]) begin
                o_stat_d = STAT_IGNORED;
              end else if (found_q &&
                           (addr_q - best_start_q) < {{(ADDR_W-SIZE_W){1'b0}}, best_size_q}) begin
                o_hit_d = 1'b1; o_key_d = best_key_q; o_cap_d = best_cap_q;
                o_play_d = best_play_q; o_bytes_d = best_size_q;
              end else begin
                o_stat_d = STAT_NOT_FOUND;
              end
            end
            CMD_READOUT: begin
              o_key_d = '0; o_stat_d = STAT_IGNORED;
            end
            default: ;
          endcase
        end
      end

      S_RDONE: begin
        if (found_eff) begin
          // hand out the held range, hold the one just found
          if (!pend_q || out_free) begin
            if (pend_q) begin
              m_valid_d = 1'b1; o_hit_d = 1'b1; o_key_d = pend_key_q; o_cap_d = pend_cap_q;
              o_play_d = pend_play_q; o_bytes_d = pend_size_q; o_chg_d = chg_q;
              o_last_d = 1'b0; o_stat_d = STAT_OK;
            end
            pend_d = 1'b1; pend_key_d = best_key_q; pend_cap_d = best_cap_q;
            pend_play_d = best_play_q; pend_size_d = best_size_q;
            prev_d = best_start_q; have_prev_d = 1'b1;
            n_d = n_q + 1'b1;
            if (n_d == NW'(RESULT_CAP)) begin
              state_d = S_RDONE;
            end else begin
              state_d = S_SCAN; cnt_d = '0; found_d = 1'b0;
            end
          end
        end else if (out_free) begin
          m_valid_d = 1'b1; o_chg_d = chg_q; o_last_d = 1'b1; o_stat_d = STAT_OK;
          state_d = S_IDLE;
          if (pend_q) begin
            o_hit_d = 1'b1; o_key_d = pend_key_q; o_cap_d = pend_cap_q;
            o_play_d = pend_play_q; o_bytes_d = pend_size_q;
          end else begin
            o_hit_d = 1'b0; o_key_d = '0; o_cap_d = '0; o_play_d = '0; o_bytes_d = '0;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;      cnt_q <= '0;
      valid_q <= '0;          cidx_q <= '0;         pidx_q <= '0;
      vflag_q <= 1'b0;        sflag_q <= 1'b0;
      view_inc_q <= INC_RESET; samp_inc_q <= INC_RESET; pen_q <= 1'b0;
      m_valid_q <= 1'b0;
      found_q <= 1'b0; kfound_q <= 1'b0; free_found_q <= 1'b0;
      pend_q <= 1'b0; have_prev_q <= 1'b0; n_q <= '0;
    end else begin
      state_q <= state_d;     cnt_q <= cnt_d;
      valid_q <= valid_d;     cidx_q <= cidx_d;     pidx_q <= pidx_d;
      vflag_q <= vflag_d;     sflag_q <= sflag_d;
      view_inc_q <= view_inc_d; samp_inc_q <= samp_inc_d; pen_q <= pen_d;
      m_valid_q <= m_valid_d;
      found_q <= found_d; kfound_q <= kfound_d; free_found_q <= free_found_d;
      pend_q <= pend_d; have_prev_q <= have_prev_d; n_q <= n_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; key_q <= key_d; kind_q <= kind_d; count_q <= count_d;
    addr_q <= addr_d; side_q <= side_d;
    e_idx_q <= e_idx_d; e_kind_q <= e_kind_d; e_cap_q <= e_cap_d; e_play_q <= e_play_d;
    free_idx_q <= free_idx_d;
    mc_q <= mc_d; mp0_q <= mp0_d; mp1_q <= mp1_d;
    best_key_q <= best_key_d; best_cap_q <= best_cap_d; best_play_q <= best_play_d;
    best_size_q <= best_size_d; best_start_q <= best_start_d; prev_q <= prev_d;
    pend_key_q <= pend_key_d; pend_cap_q <= pend_cap_d; pend_play_q <= pend_play_d;
    pend_size_q <= pend_size_d; chg_q <= chg_d;
    o_hit_q <= o_hit_d; o_chg_q <= o_chg_d; o_last_q <= o_last_d; o_key_q <= o_key_d;
    o_cap_q <= o_cap_d; o_play_q <= o_play_d; o_bytes_q <= o_bytes_d; o_stat_q <= o_stat_d;
  end

  // ports
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b0, o_bytes_q, o_play_q, o_cap_q, o_key_q};
  assign m_axis_tuser  = {o_stat_q, o_chg_q, o_hit_q};
  assign m_axis_tlast  = o_last_q;

  // an entry is only ever indexed while it is valid
  `DRT_ASSERT_NOW(a_idx_valid, clk_i, rst_ni, 1'b1, ((cidx_q | pidx_q) & ~valid_q) == '0)
  // readout never lists more than the cap
  `DRT_ASSERT_NOW(a_cap, clk_i, rst_ni, 1'b1, n_q <= NW'(RESULT_CAP))
  // a real command keeps the input closed on the next cycle
  `DRT_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_take, !s_axis_tready)

endmodule
